FILE: design/sparse_coordinate_index_table_defines.svh
// ----------------------------------------------------------------------------
// Sparse coordinate index table: assertion macros
// Concurrent check macros used by the top module. Defining NO_ASSERTIONS
// turns every check into an empty statement.
// ----------------------------------------------------------------------------
`ifndef SPARSE_COORDINATE_INDEX_TABLE_DEFINES_SVH
`define SPARSE_COORDINATE_INDEX_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define SCIT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scit: same-cycle check failed");

// Next-cycle implication.
`define SCIT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scit: next-cycle check failed");

`else

`define SCIT_ASSERT_IMP(label, clk, rst, ante, cons)
`define SCIT_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: design/scit_pkg.sv
// ----------------------------------------------------------------------------
// Sparse coordinate index table package
// Field widths, command and status codes, register indexes and the control
// group that travels along the search chain.
// ----------------------------------------------------------------------------
package scit_pkg;

   localparam int CMD_W       = 2;
   localparam int BATCH_W     = 8;
   localparam int COORD_W     = 16;
   localparam int STEP_W      = 16;
   localparam int STATUS_W    = 3;
   localparam int ID_W        = 10;
   localparam int COUNT_OUT_W = 11;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 16;
   localparam int MAX_DIMS    = 3;
   localparam int FULL_KEY_W  = BATCH_W + MAX_DIMS * COORD_W;

   // The search chain: slot s lives in cell s mod CELL_COUNT, row s / CELL_COUNT.
   localparam int CELL_COUNT  = 32;
   localparam int CELL_W      = 5;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_NEW   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FOUND = 3'd1;
   localparam logic [STATUS_W-1:0] ST_MISS  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DUP   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL  = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_QUANT_STEP    = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STRICT_UNIQUE = 4'd1;

   typedef struct packed {
      logic valid;
      logic last;
      logic hit;
   } tok_ctl_type;

endpackage

FILE: design/scit_ifs.sv
// ----------------------------------------------------------------------------
// Sparse coordinate index table channels
// Valid/ready channels for commands, results and register writes.
// ----------------------------------------------------------------------------
interface scit_req_if import scit_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CMD_W-1:0]          cmd;
   logic [BATCH_W-1:0]        batch;
   logic signed [COORD_W-1:0] coord_x;
   logic signed [COORD_W-1:0] coord_y;
   logic signed [COORD_W-1:0] coord_z;

   modport source (output valid, cmd, batch, coord_x, coord_y, coord_z, input ready);
   modport sink   (input valid, cmd, batch, coord_x, coord_y, coord_z, output ready);
endinterface

interface scit_rsp_if import scit_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic [ID_W-1:0]        entry_index;
   logic [COUNT_OUT_W-1:0] entry_count;

   modport source (output valid, status, entry_index, entry_count, input ready);
   modport sink   (input valid, status, entry_index, entry_count, output ready);
endinterface

interface scit_csr_if import scit_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/sparse_coordinate_index_table.sv
// ----------------------------------------------------------------------------
// Sparse coordinate index table
// Maps a batch index plus up to three quantized coordinates to dense ids
// handed out in first-seen order. One transaction in flight at a time: an
// insert or lookup first runs the 16-step divider in each coordinate lane,
// then passes through the 32-cell search chain, one row of 32 keys entering
// per cycle for each row that holds live keys. Clear and unused commands
// skip both and go straight to the result. The table is tracked by a fill
// count, so there is no clearing pass after reset or clear. A new command is
// taken while a finished result still waits on the output.
// ----------------------------------------------------------------------------
`include "sparse_coordinate_index_table_defines.svh"

module sparse_coordinate_index_table import scit_pkg::*; #(
   parameter int CAPACITY     = 1024,
   parameter int SPATIAL_DIMS = 3
) (
   input  logic       clock,
   input  logic       reset,
   scit_req_if.sink   req_chan,
   scit_rsp_if.source rsp_chan,
   scit_csr_if.sink   csr_chan
);

   localparam int USED_DIMS = (SPATIAL_DIMS < MAX_DIMS) ? SPATIAL_DIMS : MAX_DIMS;
   localparam int KEY_W     = BATCH_W + USED_DIMS * COORD_W;
   localparam int ROWS      = (CAPACITY + CELL_COUNT - 1) / CELL_COUNT;
   localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int SLOT_W    = ROW_W + CELL_W;
   localparam int CNT_W     = SLOT_W + 1;
   localparam int NROW_W    = ROW_W + 1;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_QUANT  = 2'd1;
   localparam logic [1:0] S_SEARCH = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [CMD_W-1:0]       cmd_ff, cmd_in;
   logic [BATCH_W-1:0]     batch_ff, batch_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic [NROW_W-1:0]      issue_cnt_ff, issue_cnt_in;
   tok_ctl_type            issue_ctl_ff, issue_ctl_in;
   logic [ROW_W-1:0]       issue_row_ff, issue_row_in;
   logic                   found_ff, found_in;
   logic [SLOT_W-1:0]      found_slot_ff, found_slot_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [STEP_W-1:0]      quant_step_ff;
   logic                   strict_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]        rsp_index_ff, rsp_index_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;

   logic                      req_fire;
   logic                      out_free;
   logic                      needs_key;
   logic                      insert_go;
   logic [STEP_W-1:0]         step_eff;
   logic                      quant_start;
   logic                      quant_done;
   logic signed [COORD_W-1:0] coord_lane [MAX_DIMS];
   logic [COORD_W-1:0]        lane_value [MAX_DIMS];
   logic [MAX_DIMS-1:0]       lane_done;
   logic [FULL_KEY_W-1:0]     key_full;
   logic [CNT_W-1:0]          round_up;
   logic [NROW_W-1:0]         nrows;
   logic [31:0]               slot_wide;
   logic [31:0]               count_wide;
   logic [31:0]               count_next_wide;
   logic [CELL_COUNT-1:0]     wr_en;

   tok_ctl_type       chain_ctl  [CELL_COUNT+1];
   logic [ROW_W-1:0]  chain_row  [CELL_COUNT+1];
   logic [SLOT_W-1:0] chain_slot [CELL_COUNT+1];

   assign req_fire     = req_chan.valid & req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign csr_chan.ready = 1'b1;
   assign out_free     = ~rsp_valid_ff | rsp_chan.ready;
   assign needs_key    = (req_chan.cmd == CMD_INSERT) | (req_chan.cmd == CMD_LOOKUP);
   assign step_eff     = (quant_step_ff == '0) ? 16'd1 : quant_step_ff;
   assign quant_start  = req_fire & needs_key;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         quant_step_ff <= 16'd1;
         strict_ff     <= 1'b0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_QUANT_STEP:    quant_step_ff <= csr_chan.data[STEP_W-1:0];
            REG_STRICT_UNIQUE: strict_ff     <= csr_chan.data[0];
            default: begin
            end
         endcase
      end
   end

   // Coordinate lanes, one quantizer per used lane; unused lanes are zero.
   assign coord_lane[0] = req_chan.coord_x;
   assign coord_lane[1] = req_chan.coord_y;
   assign coord_lane[2] = req_chan.coord_z;

   for (genvar d = 0; d < MAX_DIMS; d++) begin : g_lane
      if (d < USED_DIMS) begin : g_used
         scit_quant u_quant (
            .clock (clock),
            .reset (reset),
            .start (quant_start),
            .coord (coord_lane[d]),
            .step  (step_eff),
            .done  (lane_done[d]),
            .value (lane_value[d])
         );
      end else begin : g_unused
         assign lane_done[d]  = 1'b1;
         assign lane_value[d] = '0;
      end
   end

   assign quant_done = &lane_done;
   assign key_full   = {batch_ff, lane_value[0], lane_value[1], lane_value[2]};

   // Rows holding live keys: ceil(count / CELL_COUNT).
   assign round_up = count_ff + CNT_W'(CELL_COUNT - 1);
   assign nrows    = round_up[CNT_W-1:CELL_W];

   // Search chain.
   assign chain_ctl[0]  = issue_ctl_ff;
   assign chain_row[0]  = issue_row_ff;
   assign chain_slot[0] = '0;

   for (genvar c = 0; c < CELL_COUNT; c++) begin : g_cell
      assign wr_en[c] = insert_go & (count_ff[CELL_W-1:0] == CELL_W'(c));

      scit_cell #(
         .ROWS     (ROWS),
         .ROW_W    (ROW_W),
         .KEY_W    (KEY_W),
         .SLOT_W   (SLOT_W),
         .CELL_IDX (c)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl_in   (chain_ctl[c]),
         .row_in   (chain_row[c]),
         .slot_in  (chain_slot[c]),
         .ctl_out  (chain_ctl[c+1]),
         .row_out  (chain_row[c+1]),
         .slot_out (chain_slot[c+1]),
         .key      (key_ff),
         .count    (count_ff),
         .wr_en    (wr_en[c]),
         .wr_row   (count_ff[SLOT_W-1:CELL_W]),
         .wr_key   (key_ff)
      );
   end

   assign slot_wide  = 32'(found_slot_ff);
   assign count_wide = 32'(count_ff);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      batch_in      = batch_ff;
      key_in        = key_ff;
      issue_cnt_in  = issue_cnt_ff;
      issue_ctl_in  = '0;
      issue_row_in  = issue_row_ff;
      found_in      = found_ff;
      found_slot_in = found_slot_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_count_in  = rsp_count_ff;
      insert_go     = 1'b0;
      count_next_wide = count_wide;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in       = req_chan.cmd;
               batch_in     = req_chan.batch;
               issue_cnt_in = '0;
               found_in     = 1'b0;
               state_in     = needs_key ? S_QUANT : S_FINISH;
            end
         end
         S_QUANT: begin
            if (quant_done) begin
               key_in   = key_full[FULL_KEY_W-1 -: KEY_W];
               state_in = (nrows == '0) ? S_FINISH : S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (issue_cnt_ff < nrows) begin
               issue_ctl_in = '{valid: 1'b1,
                                last:  (issue_cnt_ff == nrows - NROW_W'(1)),
                                hit:   1'b0};
               issue_row_in = issue_cnt_ff[ROW_W-1:0];
               issue_cnt_in = issue_cnt_ff + NROW_W'(1);
            end
            if (chain_ctl[CELL_COUNT].valid) begin
               if (chain_ctl[CELL_COUNT].hit) begin
                  found_in      = 1'b1;
                  found_slot_in = chain_slot[CELL_COUNT];
               end
               if (chain_ctl[CELL_COUNT].last) begin
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = '0;
               priority if (cmd_ff == CMD_CLEAR) begin
                  rsp_status_in   = ST_NEW;
                  count_next_wide = '0;
               end else if ((cmd_ff != CMD_INSERT) && (cmd_ff != CMD_LOOKUP)) begin
                  rsp_status_in = ST_MISS;
               end else if (found_ff) begin
                  if ((cmd_ff == CMD_INSERT) && strict_ff) begin
                     rsp_status_in = ST_DUP;
                  end else begin
                     rsp_status_in = ST_FOUND;
                     rsp_index_in  = slot_wide[ID_W-1:0];
                  end
               end else if (cmd_ff == CMD_LOOKUP) begin
                  rsp_status_in = ST_MISS;
               end else if (count_ff >= CNT_W'(CAPACITY)) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  rsp_status_in   = ST_NEW;
                  rsp_index_in    = count_wide[ID_W-1:0];
                  insert_go       = 1'b1;
                  count_next_wide = count_wide + 32'd1;
               end
               count_in     = count_next_wide[CNT_W-1:0];
               rsp_count_in = count_next_wide[COUNT_OUT_W-1:0];
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         issue_ctl_ff <= '0;
         found_ff     <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ctl_ff <= issue_ctl_in;
         found_ff     <= found_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      batch_ff      <= batch_in;
      key_ff        <= key_in;
      issue_cnt_ff  <= issue_cnt_in;
      issue_row_ff  <= issue_row_in;
      found_slot_ff <= found_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.entry_index = rsp_index_ff;
   assign rsp_chan.entry_count = rsp_count_ff;

   // Tokens leave the chain only while a search is running.
   `SCIT_ASSERT_IMP(a_chain_in_search, clock, reset, chain_ctl[CELL_COUNT].valid, state_ff == S_SEARCH)
   // A key is stored only while the table has room.
   `SCIT_ASSERT_IMP(a_write_below_cap, clock, reset, wr_en != '0, count_ff < CNT_W'(CAPACITY))
   // A finished command always lands in the output register.
   `SCIT_ASSERT_NXT(a_finish_to_rsp, clock, reset, (state_ff == S_FINISH) && out_free, rsp_valid_ff)

endmodule

FILE: design/scit_quant.sv
// ----------------------------------------------------------------------------
// Coordinate quantizer
// Truncates one signed coordinate toward zero to a multiple of the grid
// step: a restoring divider on the magnitude, one quotient bit per cycle,
// then a registered multiply back by the step and the sign restored.
// ----------------------------------------------------------------------------
module scit_quant import scit_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [COORD_W-1:0] coord,
   input  logic [STEP_W-1:0]         step,
   output logic                      done,
   output logic [COORD_W-1:0]        value
);

   localparam logic [1:0] P_IDLE = 2'd0;
   localparam logic [1:0] P_DIV  = 2'd1;
   localparam logic [1:0] P_MUL  = 2'd2;
   localparam logic [1:0] P_DONE = 2'd3;

   logic [1:0]           phase_ff, phase_in;
   logic [3:0]           cnt_ff, cnt_in;
   logic [STEP_W-1:0]    rem_ff, rem_in;
   logic [COORD_W-1:0]   quo_ff, quo_in;
   logic [STEP_W-1:0]    div_ff, div_in;
   logic                 neg_ff, neg_in;
   logic [2*STEP_W-1:0]  prod_ff, prod_in;

   logic [COORD_W-1:0]   coord_u;
   logic [COORD_W-1:0]   coord_mag;
   logic [STEP_W:0]      shifted;
   logic [STEP_W+1:0]    diff;
   logic                 ge;

   assign coord_u   = coord;
   // The magnitude of the most negative value still fits as unsigned.
   assign coord_mag = coord_u[COORD_W-1] ? (~coord_u + 16'd1) : coord_u;
   assign shifted   = {rem_ff, quo_ff[COORD_W-1]};
   assign diff      = {1'b0, shifted} - {2'b00, div_ff};
   assign ge        = ~diff[STEP_W+1];

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      neg_in   = neg_ff;
      prod_in  = prod_ff;
      unique case (phase_ff)
         P_IDLE: begin
            if (start) begin
               phase_in = P_DIV;
               cnt_in   = '0;
               rem_in   = '0;
               quo_in   = coord_mag;
               div_in   = step;
               neg_in   = coord_u[COORD_W-1];
            end
         end
         P_DIV: begin
            rem_in = ge ? diff[STEP_W-1:0] : shifted[STEP_W-1:0];
            quo_in = {quo_ff[COORD_W-2:0], ge};
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               phase_in = P_MUL;
            end
         end
         P_MUL: begin
            prod_in  = {{STEP_W{1'b0}}, quo_ff} * {{COORD_W{1'b0}}, div_ff};
            phase_in = P_DONE;
         end
         P_DONE: begin
            phase_in = P_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      div_ff  <= div_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
   end

   assign done  = (phase_ff == P_DONE);
   assign value = neg_ff ? (~prod_ff[COORD_W-1:0] + 16'd1) : prod_ff[COORD_W-1:0];

endmodule

FILE: design/scit_cell.sv
// ----------------------------------------------------------------------------
// Search chain cell
// Holds one column of the key table in a small memory. A search token comes
// in from the left neighbour, the cell reads its key at the token's row,
// compares it with the broadcast search key and hands the token on.
// ----------------------------------------------------------------------------
module scit_cell import scit_pkg::*; #(
   parameter int ROWS     = 32,
   parameter int ROW_W    = 5,
   parameter int KEY_W    = 56,
   parameter int SLOT_W   = 10,
   parameter int CELL_IDX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  tok_ctl_type       ctl_in,
   input  logic [ROW_W-1:0]  row_in,
   input  logic [SLOT_W-1:0] slot_in,
   output tok_ctl_type       ctl_out,
   output logic [ROW_W-1:0]  row_out,
   output logic [SLOT_W-1:0] slot_out,
   input  logic [KEY_W-1:0]  key,
   input  logic [SLOT_W:0]   count,
   input  logic              wr_en,
   input  logic [ROW_W-1:0]  wr_row,
   input  logic [KEY_W-1:0]  wr_key
);

   logic [KEY_W-1:0]  bank_mem [ROWS];
   logic [KEY_W-1:0]  rd_ff;
   tok_ctl_type       ctl_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [SLOT_W-1:0] slot_ff;

   logic [SLOT_W-1:0] own_slot;
   logic              in_range;
   logic              own_hit;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bank_mem[wr_row] <= wr_key;
      end
      rd_ff   <= bank_mem[row_in];
      row_ff  <= row_in;
      slot_ff <= slot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   // Only slots below the fill count hold live keys; the rest are stale.
   assign own_slot = {row_ff, CELL_W'(CELL_IDX)};
   assign in_range = ({1'b0, own_slot} < count);
   assign own_hit  = ctl_ff.valid & in_range & (rd_ff == key);

   assign ctl_out  = '{valid: ctl_ff.valid, last: ctl_ff.last, hit: ctl_ff.hit | own_hit};
   assign row_out  = row_ff;
   assign slot_out = own_hit ? own_slot : slot_ff;

endmodule

FILE: tb/scit_checker.sv
// ----------------------------------------------------------------------------
// Sparse coordinate index table checker
// Watches the command, result and register channels, keeps its own copy of
// the coordinate table and the register settings, works out the outcome of
// every accepted command and compares each result field against it in order.
// ----------------------------------------------------------------------------
module scit_checker #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic clock,
   input  logic reset,
   scit_req_if  req,
   scit_rsp_if  rsp,
   scit_csr_if  csr,
   output int   fail_count,
   output int   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import scit_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [ID_W-1:0]        entry_index;
      logic [COUNT_OUT_W-1:0] entry_count;
   } outcome_type;

   outcome_type           pending_outcomes[$];
   logic [FULL_KEY_W-1:0] held_keys[TABLE_DEPTH];
   int                    key_count;
   logic [STEP_W-1:0]     grid_step;
   logic                  strict_mode;

   // Truncates a coordinate toward zero to a multiple of the grid step.
   function automatic logic [COORD_W-1:0] snap_to_grid(input logic [COORD_W-1:0] raw);
      int divisor;
      int value;
      divisor = (grid_step == '0) ? 1 : int'(grid_step);
      value   = int'($signed(raw));
      value   = (value / divisor) * divisor;
      return value[COORD_W-1:0];
   endfunction

   // Applies one command to the table copy and returns the result it gives.
   // Ids equal the slot number, as slots are filled in first-seen order.
   function automatic outcome_type resolve_command(input logic [CMD_W-1:0]   cmd,
                                                   input logic [BATCH_W-1:0] batch,
                                                   input logic [COORD_W-1:0] cx,
                                                   input logic [COORD_W-1:0] cy,
                                                   input logic [COORD_W-1:0] cz);
      outcome_type           result;
      logic [FULL_KEY_W-1:0] key;
      int                    slot;
      result.status      = ST_MISS;
      result.entry_index = '0;
      slot               = -1;
      case (cmd)
         CMD_CLEAR: begin
            key_count     = 0;
            result.status = ST_NEW;
         end
         CMD_INSERT, CMD_LOOKUP: begin
            key = {batch, snap_to_grid(cx), snap_to_grid(cy), snap_to_grid(cz)};
            for (int i = 0; i < key_count && slot < 0; i++)
               if (held_keys[i] == key) slot = i;
            if (slot >= 0) begin
               if (cmd == CMD_INSERT && strict_mode) begin
                  result.status = ST_DUP;
               end else begin
                  result.status      = ST_FOUND;
                  result.entry_index = slot[ID_W-1:0];
               end
            end else if (cmd == CMD_LOOKUP) begin
               result.status = ST_MISS;
            end else if (key_count >= TABLE_DEPTH) begin
               result.status = ST_FULL;
            end else begin
               held_keys[key_count] = key;
               result.status        = ST_NEW;
               result.entry_index   = key_count[ID_W-1:0];
               key_count++;
            end
         end
         default: ;
      endcase
      result.entry_count = key_count[COUNT_OUT_W-1:0];
      return result;
   endfunction

   task automatic note_mismatch(input string what, input int want, input int got);
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         pending_outcomes.delete();
         key_count   = 0;
         grid_step   = STEP_W'(1);
         strict_mode = 1'b0;
         fail_count  = 0;
      end else begin
         if (csr.valid && csr.ready) begin
            case (csr.index)
               REG_QUANT_STEP:    grid_step   = csr.data[STEP_W-1:0];
               REG_STRICT_UNIQUE: strict_mode = csr.data[0];
               default: ;
            endcase
         end
         // The older transaction is retired before a new one is recorded.
         if (rsp.valid && rsp.ready) begin
            if (pending_outcomes.size() == 0) begin
               fail_count++;
               $display("%0t: result with none expected, got status %0d index %0d count %0d",
                        $time, rsp.status, rsp.entry_index, rsp.entry_count);
            end else begin
               want = pending_outcomes.pop_front();
               if (want.status != rsp.status)
                  note_mismatch("status", int'(want.status), int'(rsp.status));
               if (want.entry_index != rsp.entry_index)
                  note_mismatch("entry_index", int'(want.entry_index),
                                int'(rsp.entry_index));
               if (want.entry_count != rsp.entry_count)
                  note_mismatch("entry_count", int'(want.entry_count),
                                int'(rsp.entry_count));
            end
         end
         if (req.valid && req.ready)
            pending_outcomes.insert(pending_outcomes.size(),
                                    resolve_command(req.cmd, req.batch, req.coord_x,
                                                    req.coord_y, req.coord_z));
      end
      outstanding = pending_outcomes.size();
   end

endmodule

FILE: tb/tb_sparse_coordinate_index_table.sv
// ----------------------------------------------------------------------------
// Sparse coordinate index table testbench
// Drives directed and random insert, lookup and clear commands under several
// grid steps and both duplicate policies, fills the table past its capacity,
// and stalls both channels at random. The checker does all result checking.
// ----------------------------------------------------------------------------
module tb_sparse_coordinate_index_table;
   timeunit 1ns;
   timeprecision 1ps;

   import scit_pkg::*;

   localparam int               TABLE_DEPTH    = 1024;
   localparam int               WATCHDOG_LIMIT = 2000;
   localparam int               POINT_MEMORY   = 64;
   localparam logic [CMD_W-1:0] CMD_UNUSED     = 2'd3;

   typedef struct packed {
      logic [BATCH_W-1:0] batch;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
   } point_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   int        fail_count;
   int        outstanding;
   int        idle_cycles = 0;
   int        rsp_stall = 0;
   bit        rsp_calm = 1'b0;
   bit        req_calm = 1'b0;
   point_type recent_points[$];

   scit_req_if req_chan ();
   scit_rsp_if rsp_chan ();
   scit_csr_if csr_chan ();

   sparse_coordinate_index_table #(
      .CAPACITY     (TABLE_DEPTH),
      .SPATIAL_DIMS (3)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   scit_checker #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .rsp         (rsp_chan),
      .csr         (csr_chan),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result back-pressure: mostly short stalls, now and then a long one, and
   // calm stretches in which the result side never stalls.
   always @(negedge clock) begin
      if ($urandom_range(0, 299) == 0) rsp_calm = !rsp_calm;
      if (rsp_stall > 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_chan.ready <= 1'b1;
         if (!rsp_calm && $urandom_range(0, 99) < 25)
            rsp_stall = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 40)
                                                     : $urandom_range(1, 3);
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("sparse_coordinate_index_table test failed");
         $finish;
      end
   end

   // Presents one command after a random gap and holds it until accepted.
   // Valid stays high afterwards, so the next call either replaces the
   // payload at the following falling edge or drops valid for a gap.
   task automatic send_command(input logic [CMD_W-1:0]   cmd,
                               input logic [BATCH_W-1:0] batch,
                               input logic [COORD_W-1:0] x,
                               input logic [COORD_W-1:0] y,
                               input logic [COORD_W-1:0] z);
      int gap;
      int r;
      if ($urandom_range(0, 149) == 0) req_calm = !req_calm;
      r = $urandom_range(0, 99);
      if (req_calm || r < 60)
         gap = 0;
      else
         gap = (r < 93) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.cmd     <= cmd;
      req_chan.batch   <= batch;
      req_chan.coord_x <= x;
      req_chan.coord_y <= y;
      req_chan.coord_z <= z;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic send_point(input logic [CMD_W-1:0] cmd, input point_type p);
      send_command(cmd, p.batch, p.x, p.y, p.z);
   endtask

   // Holds the command side until every outstanding result has arrived.
   task automatic settle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0]  index,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] grid, input logic strict);
      settle();
      write_reg(REG_QUANT_STEP, grid);
      write_reg(REG_STRICT_UNIQUE, {{(CSR_DATA_W-1){1'b0}}, strict});
   endtask

   // Full-range coordinates with the extremes and values near zero favoured.
   function automatic logic [COORD_W-1:0] rand_coord();
      logic [COORD_W-1:0] v;
      v = COORD_W'($urandom);
      case ($urandom_range(0, 9))
         0: v = {1'b1, {(COORD_W-1){1'b0}}};
         1: v = {1'b0, {(COORD_W-1){1'b1}}};
         2: v = COORD_W'($urandom_range(0, 16) - 8);
         default: ;
      endcase
      return v;
   endfunction

   function automatic point_type fresh_point();
      point_type p;
      p.batch = BATCH_W'($urandom);
      p.x     = rand_coord();
      p.y     = rand_coord();
      p.z     = rand_coord();
      return p;
   endfunction

   // A remembered point, sometimes nudged by up to two so that it lands in the
   // same or a nearby grid cell.
   function automatic point_type nearby_point();
      point_type p;
      p = recent_points[$urandom_range(0, recent_points.size() - 1)];
      if ($urandom_range(0, 3) == 0) p.x = COORD_W'(p.x + $urandom_range(0, 2));
      if ($urandom_range(0, 3) == 0) p.y = COORD_W'(p.y - $urandom_range(0, 2));
      if ($urandom_range(0, 3) == 0) p.z = COORD_W'(p.z + $urandom_range(0, 2));
      return p;
   endfunction

   function automatic void remember(input point_type p);
      recent_points.insert(recent_points.size(), p);
      if (recent_points.size() > POINT_MEMORY) void'(recent_points.pop_front());
   endfunction

   task automatic random_phase(input int count);
      point_type p;
      int        r;
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (recent_points.size() == 0 || $urandom_range(0, 2) == 0)
            p = fresh_point();
         else
            p = nearby_point();
         if (r < 3) begin
            send_point(CMD_CLEAR, p);
         end else if (r < 6) begin
            send_point(CMD_UNUSED, p);
         end else if (r < 50) begin
            send_point(CMD_INSERT, p);
            remember(p);
         end else begin
            send_point(CMD_LOOKUP, p);
         end
      end
   endtask

   initial begin
      point_type p;
      req_chan.valid   = 1'b0;
      req_chan.cmd     = CMD_INSERT;
      req_chan.batch   = '0;
      req_chan.coord_x = '0;
      req_chan.coord_y = '0;
      req_chan.coord_z = '0;
      rsp_chan.ready   = 1'b0;
      csr_chan.valid   = 1'b0;
      csr_chan.index   = REG_QUANT_STEP;
      csr_chan.data    = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Register defaults: no quantization, duplicates allowed.
      send_command(CMD_INSERT, 8'd0,   16'h0000, 16'h0000, 16'h0000);
      send_command(CMD_INSERT, 8'd255, 16'h7fff, 16'h7fff, 16'h7fff);
      send_command(CMD_INSERT, 8'd0,   16'h8000, 16'h8000, 16'h8000);
      send_command(CMD_INSERT, 8'd255, 16'hffff, 16'h0001, 16'hffff);
      send_command(CMD_INSERT, 8'd0,   16'h0000, 16'h0000, 16'h0000);
      send_command(CMD_LOOKUP, 8'd255, 16'h7fff, 16'h7fff, 16'h7fff);
      send_command(CMD_LOOKUP, 8'd1,   16'h0000, 16'h0000, 16'h0000);
      send_command(CMD_UNUSED, 8'hff,  16'hffff, 16'hffff, 16'hffff);
      send_command(CMD_CLEAR,  8'd0,   16'h0000, 16'h0000, 16'h0000);
      send_command(CMD_LOOKUP, 8'd0,   16'h0000, 16'h0000, 16'h0000);
      send_command(CMD_INSERT, 8'd0,   16'h0000, 16'h0000, 16'h0000);

      // A zero grid step behaves as no quantization; strict mode rejects.
      configure(16'd0, 1'b1);
      send_command(CMD_INSERT, 8'd0, 16'h0000, 16'h0000, 16'h0000);
      send_command(CMD_INSERT, 8'd9, 16'h0005, 16'hfffb, 16'h0003);
      send_command(CMD_LOOKUP, 8'd9, 16'h0005, 16'hfffb, 16'h0003);

      // The widest step folds every coordinate onto zero.
      configure(16'hffff, 1'b0);
      send_command(CMD_INSERT, 8'd1, 16'h8000, 16'h7fff, 16'hffff);
      send_command(CMD_LOOKUP, 8'd1, 16'h0000, 16'h0000, 16'h0000);

      // Truncation toward zero on both sides of the origin.
      configure(16'd10, 1'b0);
      send_command(CMD_INSERT, 8'd2, 16'hffed, 16'h0013, 16'hfff6);
      send_command(CMD_LOOKUP, 8'd2, 16'hfff5, 16'h000b, 16'hffed);
      send_command(CMD_LOOKUP, 8'd2, 16'hffec, 16'h0013, 16'hfff6);
      send_command(CMD_INSERT, 8'd2, 16'hfff7, 16'h0009, 16'hfff7);

      configure(16'd1, 1'b0);
      random_phase(55);
      configure(16'd0, 1'b1);
      random_phase(55);
      configure(16'hffff, 1'b0);
      random_phase(55);
      configure(16'd3, 1'b1);
      random_phase(55);
      configure(16'd16, 1'b0);
      random_phase(55);
      configure(CSR_DATA_W'($urandom_range(2, 300)), 1'b1);
      random_phase(55);

      // Fill the table past capacity with distinct keys, then probe it full.
      configure(16'd1, 1'b0);
      send_point(CMD_CLEAR, fresh_point());
      for (int i = 0; i < TABLE_DEPTH + 6; i++) begin
         p   = fresh_point();
         p.x = COORD_W'(i - TABLE_DEPTH / 2);
         send_point(CMD_INSERT, p);
         remember(p);
      end
      repeat (12) send_point($urandom_range(0, 1) ? CMD_INSERT : CMD_LOOKUP, nearby_point());
      send_point(CMD_INSERT, fresh_point());
      configure(16'd1, 1'b1);
      repeat (8) send_point($urandom_range(0, 1) ? CMD_INSERT : CMD_LOOKUP, nearby_point());
      send_point(CMD_CLEAR, fresh_point());

      configure(CSR_DATA_W'($urandom), 1'b0);
      random_phase(55);

      settle();
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("sparse_coordinate_index_table test passed");
      else
         $display("sparse_coordinate_index_table test failed");
      $finish;
   end

endmodule

FILE: sparse_coordinate_index_table.f
+incdir+design
design/scit_pkg.sv
design/scit_ifs.sv
design/scit_quant.sv
design/scit_cell.sv
design/sparse_coordinate_index_table.sv
tb/scit_checker.sv
tb/tb_sparse_coordinate_index_table.sv
